// ===== hw/rtl/tdflp_pkg.sv =====
// Package for the three-field decimal line parser.
// Holds widths, character codes, the token and status types and field helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tdflp_pkg;

  localparam int NUM_WIDTH   = 32;
  localparam int EXT_WIDTH   = NUM_WIDTH + 4;
  localparam int FIELD_WIDTH = 32;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef logic [NUM_WIDTH-1:0]   acc_t;
  typedef logic [EXT_WIDTH-1:0]   ext_t;
  typedef logic [FIELD_WIDTH-1:0] field_t;

  typedef enum logic [1:0] {
    TK_DIGIT = 2'd0,
    TK_BLANK = 2'd1,
    TK_OTHER = 2'd2,
    TK_EOL   = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [3:0] digit;
  } token_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD      = 2'd1,
    ST_MISSING  = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_FIRST  = 3'd1,
    PH_GAP2   = 3'd2,
    PH_SECOND = 3'd3,
    PH_GAP3   = 3'd4,
    PH_THIRD  = 3'd5,
    PH_TRAIL  = 3'd6
  } phase_t;

  function automatic field_t to_field(input acc_t acc);
    return FIELD_WIDTH'(acc);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tdflp_front.sv =====
// Front end of the line parser: takes bytes from the input stream and
// classifies each into a token for the queue. Depends on tdflp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tdflp_front (
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [7:0]       s_tdata,   // [7:0] ch
  input  wire logic             s_tlast,   // end_of_line
  input  wire logic             q_full,
  output logic                  push,
  output tdflp_pkg::token_t     token
);

  logic is_digit;
  logic is_blank;

  assign is_digit = (s_tdata >= tdflp_pkg::CH_ZERO) && (s_tdata <= tdflp_pkg::CH_NINE);
  assign is_blank = (s_tdata == tdflp_pkg::CH_SPACE) ||
                    ((s_tdata >= tdflp_pkg::CH_TAB) && (s_tdata <= tdflp_pkg::CH_CR));

  assign s_tready = !q_full;
  assign push     = s_tvalid && !q_full;

  always_comb begin
    token.digit = s_tdata[3:0];
    if (s_tlast) begin
      token.kind = tdflp_pkg::TK_EOL;
    end else if (is_digit) begin
      token.kind = tdflp_pkg::TK_DIGIT;
    end else if (is_blank) begin
      token.kind = tdflp_pkg::TK_BLANK;
    end else begin
      token.kind = tdflp_pkg::TK_OTHER;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tdflp_queue.sv =====
// Short token queue between the front end and the back end of the parser.
// Depends on tdflp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tdflp_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire tdflp_pkg::token_t push_token,
  output logic                   full,
  input  wire logic              pop,
  output logic                   head_valid,
  output tdflp_pkg::token_t      head
);

  tdflp_pkg::token_t                   slots [tdflp_pkg::QUEUE_DEPTH];
  logic [tdflp_pkg::QUEUE_AW-1:0]      wr_ptr;
  logic [tdflp_pkg::QUEUE_AW-1:0]      rd_ptr;
  logic [tdflp_pkg::QUEUE_CW-1:0]      count;
  logic                                do_pop;

  assign full       = (count == tdflp_pkg::QUEUE_CW'(tdflp_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_token;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tdflp_back.sv =====
// Back end of the parser: walks the field phases, accumulates the three
// decimal values with overflow check and holds the result register.
// Depends on tdflp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tdflp_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              tok_valid,
  input  wire tdflp_pkg::token_t tok,
  output logic                   pop,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [103:0]           m_tdata    // [1:0] status, [33:2] first_id,
                                            // [65:34] second_id, [97:66] duration
);

  tdflp_pkg::phase_t  phase, phase_next;
  tdflp_pkg::status_t err, err_next;
  tdflp_pkg::acc_t    first_acc, first_acc_next;
  tdflp_pkg::acc_t    second_acc, second_acc_next;
  tdflp_pkg::acc_t    third_acc, third_acc_next;

  tdflp_pkg::acc_t    sel_acc;
  tdflp_pkg::ext_t    sel_ext;
  tdflp_pkg::ext_t    prod;
  tdflp_pkg::acc_t    prod_acc;
  logic               ovf;
  logic               is_eol;
  logic               is_digit;
  logic               is_blank;
  logic               live;

  tdflp_pkg::status_t final_status;
  logic               out_valid;
  tdflp_pkg::status_t out_status;
  tdflp_pkg::field_t  out_first;
  tdflp_pkg::field_t  out_second;
  tdflp_pkg::field_t  out_third;

  assign is_eol   = (tok.kind == tdflp_pkg::TK_EOL);
  assign is_digit = (tok.kind == tdflp_pkg::TK_DIGIT);
  assign is_blank = (tok.kind == tdflp_pkg::TK_BLANK);
  assign pop      = tok_valid && (!is_eol || !out_valid || m_tready);
  assign live     = pop && !is_eol && (err == tdflp_pkg::ST_OK);

  always_comb begin
    unique case (phase) inside
      tdflp_pkg::PH_START, tdflp_pkg::PH_FIRST:  sel_acc = first_acc;
      tdflp_pkg::PH_GAP2, tdflp_pkg::PH_SECOND:  sel_acc = second_acc;
      default:                                   sel_acc = third_acc;
    endcase
  end

  // value * 10 + digit, top four bits flag overflow
  assign sel_ext  = tdflp_pkg::EXT_WIDTH'(sel_acc);
  assign prod     = (sel_ext << 3) + (sel_ext << 1) + tdflp_pkg::EXT_WIDTH'(tok.digit);
  assign ovf      = |prod[tdflp_pkg::EXT_WIDTH-1:tdflp_pkg::NUM_WIDTH];
  assign prod_acc = prod[tdflp_pkg::NUM_WIDTH-1:0];

  always_comb begin
    phase_next = phase;
    if (pop && is_eol) begin
      phase_next = tdflp_pkg::PH_START;
    end else if (live) begin
      unique case (phase)
        tdflp_pkg::PH_START: begin
          if (is_digit) phase_next = tdflp_pkg::PH_FIRST;
        end
        tdflp_pkg::PH_FIRST: begin
          if (is_blank) phase_next = tdflp_pkg::PH_GAP2;
        end
        tdflp_pkg::PH_GAP2: begin
          if (is_digit) phase_next = tdflp_pkg::PH_SECOND;
        end
        tdflp_pkg::PH_SECOND: begin
          if (is_blank) phase_next = tdflp_pkg::PH_GAP3;
        end
        tdflp_pkg::PH_GAP3: begin
          if (is_digit) phase_next = tdflp_pkg::PH_THIRD;
        end
        tdflp_pkg::PH_THIRD: begin
          if (is_blank) phase_next = tdflp_pkg::PH_TRAIL;
        end
        default: phase_next = phase;
      endcase
    end
  end

  always_comb begin
    err_next        = err;
    first_acc_next  = first_acc;
    second_acc_next = second_acc;
    third_acc_next  = third_acc;
    if (pop && is_eol) begin
      err_next        = tdflp_pkg::ST_OK;
      first_acc_next  = '0;
      second_acc_next = '0;
      third_acc_next  = '0;
    end else if (live) begin
      if (is_digit && phase != tdflp_pkg::PH_TRAIL) begin
        if (ovf) begin
          err_next = tdflp_pkg::ST_OVERFLOW;
        end else begin
          unique case (phase) inside
            tdflp_pkg::PH_START, tdflp_pkg::PH_FIRST:  first_acc_next  = prod_acc;
            tdflp_pkg::PH_GAP2, tdflp_pkg::PH_SECOND:  second_acc_next = prod_acc;
            default:                                   third_acc_next  = prod_acc;
          endcase
        end
      end else if (is_blank) begin
        if (phase == tdflp_pkg::PH_START) err_next = tdflp_pkg::ST_MISSING;
      end else begin
        err_next = tdflp_pkg::ST_BAD;
      end
    end
  end

  always_comb begin
    if (err != tdflp_pkg::ST_OK) begin
      final_status = err;
    end else if (phase == tdflp_pkg::PH_THIRD || phase == tdflp_pkg::PH_TRAIL) begin
      final_status = tdflp_pkg::ST_OK;
    end else begin
      final_status = tdflp_pkg::ST_MISSING;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= tdflp_pkg::PH_START;
      err        <= tdflp_pkg::ST_OK;
      first_acc  <= '0;
      second_acc <= '0;
      third_acc  <= '0;
      out_valid  <= 1'b0;
    end else begin
      phase      <= phase_next;
      err        <= err_next;
      first_acc  <= first_acc_next;
      second_acc <= second_acc_next;
      third_acc  <= third_acc_next;
      if (pop && is_eol) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && is_eol) begin
      out_status <= final_status;
      if (final_status == tdflp_pkg::ST_OK) begin
        out_first  <= tdflp_pkg::to_field(first_acc);
        out_second <= tdflp_pkg::to_field(second_acc);
        out_third  <= tdflp_pkg::to_field(third_acc);
      end else begin
        out_first  <= '0;
        out_second <= '0;
        out_third  <= '0;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'b0, out_third, out_second, out_first, out_status};

endmodule

`default_nettype wire

// ===== hw/rtl/three_decimal_field_line_parser.sv =====
// Three-field decimal line parser: byte stream in, one status/value record
// per line out. Uses tdflp_front, tdflp_queue, tdflp_back and tdflp_pkg.
//
// Usage:
//   Input stream: one character per item in s_tdata; an item with s_tlast
//   high closes the line and carries no character. Output stream: one record
//   per line with status (ok, bad character, missing field, overflow) and
//   the three decimal fields, all zero unless the status is ok.
//   Throughput: one input item per cycle while the token queue is not full. The back end updates
//   one accumulator per cycle with a single times-ten-plus-digit adder.
//   Path: the end marker is registered in the four-entry token queue, and
//   the record is then registered in the output register.
//   Reset: queue empties, parser returns to the start of the first field
//   with cleared accumulators, and the output register goes invalid.
//   Stall: a held record stays on m_tdata until m_tready; characters keep
//   flowing, and the next end marker waits in the queue. When the queue
//   fills, s_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module three_decimal_field_line_parser (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [7:0]    s_tdata,   // [7:0] ch
  input  wire logic          s_tlast,   // end_of_line
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [103:0]       m_tdata    // [1:0] status, [33:2] first_id,
                                        // [65:34] second_id, [97:66] duration
);

  logic              push;
  logic              q_full;
  logic              pop;
  logic              head_valid;
  tdflp_pkg::token_t push_token;
  tdflp_pkg::token_t head;

  tdflp_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .push     (push),
    .token    (push_token)
  );

  tdflp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_token (push_token),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  tdflp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (head_valid),
    .tok       (head),
    .pop       (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/tdflp_checker.sv =====
// Port-level checks for the three-field decimal line parser, bound to the
// top level. Depends on three_decimal_field_line_parser and tdflp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tdflp_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          m_tvalid,
  input wire logic          m_tready,
  input wire logic [103:0]  m_tdata
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("record dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("record changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] != tdflp_pkg::ST_OK) |-> (m_tdata[97:2] == '0))
    else $error("fields not zero on error status");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[103:98] == '0))
    else $error("padding bits set");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("record valid after reset");

endmodule

bind three_decimal_field_line_parser tdflp_checker u_tdflp_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

// ===== test/tb_three_decimal_field_line_parser.sv =====
`timescale 1ns / 1ps
// Testbench for three_decimal_field_line_parser: a table of directed lines, then random
// lines under mixed source idling and sink stalls, every output record checked by field.
// Depends on tdflp_pkg and the parser RTL.

module tb_three_decimal_field_line_parser;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 820;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASES       = 4;
  localparam int SRC_IDLE [PHASES]  = '{0, 46, 0, 17};
  localparam int SINK_STALL [PHASES] = '{0, 0, 46, 17};
  localparam logic [63:0] NUM_LIMIT =
    (tdflp_pkg::NUM_WIDTH >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF :
                                   ((64'd1 << tdflp_pkg::NUM_WIDTH) - 64'd1);

  typedef struct packed {
    tdflp_pkg::field_t  duration;
    tdflp_pkg::field_t  second_id;
    tdflp_pkg::field_t  first_id;
    tdflp_pkg::status_t status;
  } line_record_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [7:0]   s_tdata;
  logic         s_tlast;
  logic         m_tvalid;
  logic         m_tready;
  logic [103:0] m_tdata;

  three_decimal_field_line_parser u_top (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  tdflp_pkg::phase_t  line_phase;
  logic [63:0]        field_acc [3];
  tdflp_pkg::status_t line_error;

  line_record_t pending_records [$];
  logic [7:0]   line_bytes [$];
  string        directed_text [$];
  bit           directed_typed [$];
  line_record_t directed_want [$];

  int src_idle_pct;
  int sink_stall_pct;
  int fail_count;
  int records_checked;
  int lines_sent;
  int live_items;
  int cycle_count;
  int status_seen [4];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("three_decimal_field_line_parser regression: fail");
      $finish;
    end
  end

  always @(posedge clk) m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);

  function automatic bit is_blank(input logic [7:0] c);
    return c == tdflp_pkg::CH_SPACE || (c >= tdflp_pkg::CH_TAB && c <= tdflp_pkg::CH_CR);
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= tdflp_pkg::CH_ZERO && c <= tdflp_pkg::CH_NINE;
  endfunction

  function automatic void clear_line();
    line_phase   = tdflp_pkg::PH_START;
    field_acc[0] = '0;
    field_acc[1] = '0;
    field_acc[2] = '0;
    line_error   = tdflp_pkg::ST_OK;
  endfunction

  // Latch overflow instead of wrapping once the value no longer fits NUM_WIDTH bits.
  function automatic void push_digit(input int k, input logic [7:0] c);
    logic [63:0] d;
    d = 64'(c) - 64'(tdflp_pkg::CH_ZERO);
    if (field_acc[k] > (NUM_LIMIT - d) / 64'd10) line_error = tdflp_pkg::ST_OVERFLOW;
    else field_acc[k] = field_acc[k] * 64'd10 + d;
  endfunction

  function automatic bit parse_char(input logic [7:0] c, input logic eol,
                                    output line_record_t rec);
    tdflp_pkg::status_t st;
    rec = '0;
    if (eol) begin
      st = line_error;
      if (st == tdflp_pkg::ST_OK && line_phase != tdflp_pkg::PH_THIRD &&
          line_phase != tdflp_pkg::PH_TRAIL) st = tdflp_pkg::ST_MISSING;
      rec.status = st;
      if (st == tdflp_pkg::ST_OK) begin
        rec.first_id  = tdflp_pkg::field_t'(field_acc[0]);
        rec.second_id = tdflp_pkg::field_t'(field_acc[1]);
        rec.duration  = tdflp_pkg::field_t'(field_acc[2]);
      end
      clear_line();
      return 1'b1;
    end
    if (line_error != tdflp_pkg::ST_OK) return 1'b0;
    case (line_phase)
      tdflp_pkg::PH_START: begin
        if (is_digit(c)) begin
          push_digit(0, c);
          line_phase = tdflp_pkg::PH_FIRST;
        end else if (is_blank(c)) line_error = tdflp_pkg::ST_MISSING;
        else line_error = tdflp_pkg::ST_BAD;
      end
      tdflp_pkg::PH_FIRST: begin
        if (is_digit(c)) push_digit(0, c);
        else if (is_blank(c)) line_phase = tdflp_pkg::PH_GAP2;
        else line_error = tdflp_pkg::ST_BAD;
      end
      tdflp_pkg::PH_GAP2: begin
        if (is_digit(c)) begin
          push_digit(1, c);
          line_phase = tdflp_pkg::PH_SECOND;
        end else if (!is_blank(c)) line_error = tdflp_pkg::ST_BAD;
      end
      tdflp_pkg::PH_SECOND: begin
        if (is_digit(c)) push_digit(1, c);
        else if (is_blank(c)) line_phase = tdflp_pkg::PH_GAP3;
        else line_error = tdflp_pkg::ST_BAD;
      end
      tdflp_pkg::PH_GAP3: begin
        if (is_digit(c)) begin
          push_digit(2, c);
          line_phase = tdflp_pkg::PH_THIRD;
        end else if (!is_blank(c)) line_error = tdflp_pkg::ST_BAD;
      end
      tdflp_pkg::PH_THIRD: begin
        if (is_digit(c)) push_digit(2, c);
        else if (is_blank(c)) line_phase = tdflp_pkg::PH_TRAIL;
        else line_error = tdflp_pkg::ST_BAD;
      end
      default: begin
        if (!is_blank(c)) line_error = tdflp_pkg::ST_BAD;
      end
    endcase
    return 1'b0;
  endfunction

  task automatic add_row(input string text, input bit typed, input tdflp_pkg::status_t st,
                         input tdflp_pkg::field_t first, input tdflp_pkg::field_t second,
                         input tdflp_pkg::field_t dur);
    line_record_t rec;
    rec.status    = st;
    rec.first_id  = first;
    rec.second_id = second;
    rec.duration  = dur;
    directed_text.push_back(text);
    directed_typed.push_back(typed);
    directed_want.push_back(rec);
  endtask

  function automatic void append_text(input string text);
    for (int i = 0; i < text.len(); i++) line_bytes.push_back(text[i]);
  endfunction

  function automatic logic [7:0] random_blank();
    if ($urandom_range(0, 3) == 0)
      return 8'($urandom_range(tdflp_pkg::CH_TAB, tdflp_pkg::CH_CR));
    return tdflp_pkg::CH_SPACE;
  endfunction

  function automatic string random_number();
    logic [63:0] v;
    int          pick;
    string       txt;
    pick = $urandom_range(0, 99);
    if (pick < 45) v = 64'($urandom_range(0, 99));
    else if (pick < 65) v = 64'($urandom_range(0, 99999));
    else if (pick < 80) v = 64'($urandom);
    else if (pick < 88) v = NUM_LIMIT - 64'($urandom_range(0, 3));
    else if (pick < 95) v = NUM_LIMIT + 64'($urandom_range(1, 20));
    else v = {$urandom, $urandom};
    txt = $sformatf("%0d", v);
    if ($urandom_range(0, 9) == 0) txt = {"00", txt};
    return txt;
  endfunction

  // Mostly well-formed lines; the rest get a stray byte, a replaced byte, a cut, or pure noise.
  task automatic build_random_line();
    int pick;
    int keep;
    line_bytes.delete();
    for (int f = 0; f < 3; f++) begin
      if (f != 0) repeat ($urandom_range(1, 3)) line_bytes.push_back(random_blank());
      append_text(random_number());
    end
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) line_bytes.push_back(random_blank());
    pick = $urandom_range(0, 99);
    if (pick >= 97) begin
      line_bytes.push_back(8'($urandom));
    end else if (pick >= 92) begin
      line_bytes.delete();
      repeat ($urandom_range(0, 8)) line_bytes.push_back(8'($urandom));
    end else if (pick >= 86) begin
      keep = $urandom_range(0, line_bytes.size() - 1);
      while (line_bytes.size() > keep) void'(line_bytes.pop_back());
    end else if (pick >= 78) begin
      line_bytes[$urandom_range(0, line_bytes.size() - 1)] = 8'($urandom);
    end
  endtask

  task automatic send_item(input logic [7:0] c, input logic eol,
                           output line_record_t rec, output bit has_rec);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= eol;
    do @(posedge clk); while (!s_tready);
    if (eol || line_error == tdflp_pkg::ST_OK) live_items++;
    has_rec = parse_char(c, eol, rec);
  endtask

  task automatic send_line(input bit typed, input line_record_t typed_rec);
    line_record_t rec;
    bit           has_rec;
    foreach (line_bytes[i]) send_item(line_bytes[i], 1'b0, rec, has_rec);
    send_item(8'($urandom), 1'b1, rec, has_rec);
    pending_records.push_back(typed ? typed_rec : rec);
    lines_sent++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin : check_records
    line_record_t got;
    line_record_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[$bits(line_record_t)-1:0];
      if (pending_records.size() == 0) begin
        $error("unexpected record: status %0d", got.status);
        fail_count++;
      end else begin
        want = pending_records.pop_front();
        records_checked++;
        status_seen[want.status]++;
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          fail_count++;
        end
        if (got.first_id !== want.first_id) begin
          $error("first_id: expected %0d, got %0d", want.first_id, got.first_id);
          fail_count++;
        end
        if (got.second_id !== want.second_id) begin
          $error("second_id: expected %0d, got %0d", want.second_id, got.second_id);
          fail_count++;
        end
        if (got.duration !== want.duration) begin
          $error("duration: expected %0d, got %0d", want.duration, got.duration);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int target;
    rst            <= 1'b1;
    s_tvalid       <= 1'b0;
    s_tdata        <= '0;
    s_tlast        <= 1'b0;
    m_tready       <= 1'b0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    clear_line();

    add_row("",                                 1, tdflp_pkg::ST_MISSING,  '0, '0, '0);
    add_row(" 1 2 3",                           1, tdflp_pkg::ST_MISSING,  '0, '0, '0);
    add_row("7",                                1, tdflp_pkg::ST_MISSING,  '0, '0, '0);
    add_row("7 8",                              1, tdflp_pkg::ST_MISSING,  '0, '0, '0);
    add_row("7 8\011",                          1, tdflp_pkg::ST_MISSING,  '0, '0, '0);
    add_row("0 0 0",                            1, tdflp_pkg::ST_OK,       '0, '0, '0);
    add_row("4294967295 4294967295 4294967295", 1, tdflp_pkg::ST_OK,       '1, '1, '1);
    add_row("4294967296 1 2",                   1, tdflp_pkg::ST_OVERFLOW, '0, '0, '0);
    add_row("1 4294967296 2",                   1, tdflp_pkg::ST_OVERFLOW, '0, '0, '0);
    add_row("1 2 99999999999",                  1, tdflp_pkg::ST_OVERFLOW, '0, '0, '0);
    add_row("12a 3 4",                          1, tdflp_pkg::ST_BAD,      '0, '0, '0);
    add_row("/",                                1, tdflp_pkg::ST_BAD,      '0, '0, '0);
    add_row("1 2 3:",                           1, tdflp_pkg::ST_BAD,      '0, '0, '0);
    add_row("1 2 3 4",                          1, tdflp_pkg::ST_BAD,      '0, '0, '0);
    add_row("\377 1 2",                         1, tdflp_pkg::ST_BAD,      '0, '0, '0);
    add_row("99999999999 x",                    1, tdflp_pkg::ST_OVERFLOW, '0, '0, '0);
    add_row("1 2 x 99999999999",                1, tdflp_pkg::ST_BAD,      '0, '0, '0);
    add_row(" x",                               1, tdflp_pkg::ST_MISSING,  '0, '0, '0);
    add_row("5 6 7\011\012\013\014\015 ",       0, tdflp_pkg::ST_OK,       '0, '0, '0);
    add_row("5\011\0126\013\014 7",             0, tdflp_pkg::ST_OK,       '0, '0, '0);
    add_row("0004294967295 00 10",              0, tdflp_pkg::ST_OK,       '0, '0, '0);
    add_row("123 45 6789",                      0, tdflp_pkg::ST_OK,       '0, '0, '0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_text[r]) begin
      line_bytes.delete();
      append_text(directed_text[r]);
      send_line(directed_typed[r], directed_want[r]);
    end
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      src_idle_pct   = SRC_IDLE[p];
      sink_stall_pct = SINK_STALL[p];
      target         = live_items + RANDOM_ITEMS / PHASES;
      while (live_items < target) begin
        build_random_line();
        send_line(1'b0, '0);
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d lines over four idle/stall mixes, %0d records checked, %0d mismatches.",
             lines_sent, records_checked, fail_count);
    $display("Statuses seen: ok %0d, bad character %0d, missing field %0d, overflow %0d.",
             status_seen[tdflp_pkg::ST_OK], status_seen[tdflp_pkg::ST_BAD],
             status_seen[tdflp_pkg::ST_MISSING], status_seen[tdflp_pkg::ST_OVERFLOW]);
    if (fail_count == 0) begin
      $display("three_decimal_field_line_parser regression: pass");
    end else begin
      $display("three_decimal_field_line_parser regression: fail");
    end
    $finish;
  end

endmodule
